// File: design/tarl_pkg.sv
// shared types and constants for the threshold alert ring log
// no dependencies; imported by the controller, datapath and top level
`default_nettype none

package tarl_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned NODE_W  = 16;
  localparam int unsigned CODE_W  = 2;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CNT_W   = 7;
  localparam logic [CNT_W-1:0] MAX_RESULTS = 7'd64;

  // configuration register indexes
  localparam logic [1:0] REG_TEMP_THR = 2'd0;
  localparam logic [1:0] REG_HUM_THR  = 2'd1;
  localparam logic [1:0] REG_ELEC_THR = 2'd2;

  localparam logic [DATA_W-1:0] TEMP_THR_RST = 32'h0028_0000;
  localparam logic [DATA_W-1:0] HUM_THR_RST  = 32'h005A_0000;
  localparam logic [DATA_W-1:0] ELEC_THR_RST = 32'h00F9_0000;

  // variable kinds
  localparam logic [KIND_W-1:0] KIND_TEMP = 2'd0;
  localparam logic [KIND_W-1:0] KIND_HUM  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ELEC = 2'd2;

  // alert codes
  localparam logic [CODE_W-1:0] ALERT_NONE = 2'd0;
  localparam logic [CODE_W-1:0] ALERT_TEMP = 2'd1;
  localparam logic [CODE_W-1:0] ALERT_HUM  = 2'd2;
  localparam logic [CODE_W-1:0] ALERT_ELEC = 2'd3;

  // opcodes and result kinds
  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_READ    = 1'b1;
  localparam logic RES_SAMPLE = 1'b0;
  localparam logic RES_ENTRY  = 1'b1;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [CODE_W-1:0] code;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic capture;      // latch request fields
    logic init;         // clear search state, set up history pointers
    logic search;       // one step of the duplicate scan
    logic write;        // store the alert, bump the count
    logic hist_rd;      // read the current history slot
    logic emit_sample;  // load the sample response
    logic emit_empty;   // load the empty history result
    logic emit_entry;   // load a history entry and step the pointers
  } dp_cmd_t;

  typedef struct packed {
    logic op;
    logic alert;
    logic log_empty;
    logic n_zero;
    logic search_done;
    logic dup;
    logic out_free;
    logic hist_last;
  } dp_status_t;

endpackage

`default_nettype wire

// File: design/tarl_ctrl.sv
// controller state machine for the threshold alert ring log
// depends on tarl_pkg for the command and status structs
`default_nettype none

module tarl_ctrl
  import tarl_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_DECIDE = 8'b0000_0010,
    ST_SEARCH = 8'b0000_0100,
    ST_WRITE  = 8'b0000_1000,
    ST_SAMPLE = 8'b0001_0000,
    ST_EMPTY  = 8'b0010_0000,
    ST_HRD    = 8'b0100_0000,
    ST_HOUT   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.init = 1'b1;
        if (status.op == OP_SAMPLE) begin
          if (!status.alert) state_next = ST_SAMPLE;
          else if (status.log_empty) state_next = ST_WRITE;
          else state_next = ST_SEARCH;
        end else begin
          state_next = status.n_zero ? ST_EMPTY : ST_HRD;
        end
      end
      ST_SEARCH: begin
        cmd.search = 1'b1;
        if (status.search_done) state_next = status.dup ? ST_SAMPLE : ST_WRITE;
      end
      ST_WRITE: begin
        cmd.write  = 1'b1;
        state_next = ST_SAMPLE;
      end
      ST_SAMPLE: begin
        if (status.out_free) begin
          cmd.emit_sample = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (status.out_free) begin
          cmd.emit_empty = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_HRD: begin
        cmd.hist_rd = 1'b1;
        state_next  = ST_HOUT;
      end
      ST_HOUT: begin
        if (status.out_free) begin
          cmd.emit_entry = 1'b1;
          state_next     = status.hist_last ? ST_IDLE : ST_HRD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// File: design/tarl_dp.sv
// datapath: threshold registers, alert log memory, count, pointers, result register
// depends on tarl_pkg for types, codes and the command and status structs
`default_nettype none

module tarl_dp
  import tarl_pkg::*;
#(
  parameter int LOG_DEPTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dp_cmd_t            cmd,
  output dp_status_t              status,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [DATA_W-1:0]  cfg_data,
  input  wire logic               op,
  input  wire logic [NODE_W-1:0]  node_id,
  input  wire logic [KIND_W-1:0]  variable_kind,
  input  wire logic signed [DATA_W-1:0] sample_value,
  input  wire logic [DATA_W-1:0]  sample_time,
  input  wire logic [CNT_W-1:0]   max_count,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    result_kind,
  output logic [CODE_W-1:0]       alert_code,
  output logic                    newly_stored,
  output logic [DATA_W-1:0]       total_count,
  output logic                    entry_valid,
  output logic [NODE_W-1:0]       entry_node,
  output logic signed [DATA_W-1:0] entry_value,
  output logic [DATA_W-1:0]       entry_time,
  output logic                    last
);

  localparam int AW = $clog2(LOG_DEPTH);
  localparam int SW = $clog2(LOG_DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(LOG_DEPTH - 1);
  // slot of count value 2^32-1, reached when the history walk wraps below zero
  localparam logic [AW-1:0] TOP_SLOT = AW'(64'd4294967295 % 64'(LOG_DEPTH));
  localparam logic [SW-1:0] DEPTH_S = SW'(LOG_DEPTH);

  logic signed [DATA_W-1:0] temp_thr, hum_thr, elec_thr;
  logic [DATA_W-1:0] count;
  logic              full;
  logic [AW-1:0]     wr_ptr;

  // captured request
  logic              op_q;
  logic [NODE_W-1:0] node_q;
  logic [CODE_W-1:0] code_q;
  logic [DATA_W-1:0] value_q;
  logic [DATA_W-1:0] time_q;
  logic [CNT_W-1:0]  n_q;
  logic              wrote;

  logic [CODE_W-1:0] code_in;
  logic [CNT_W-1:0]  max_sat;
  logic [SW-1:0]     stored;
  logic [CNT_W-1:0]  stored_w;

  // search and history walk
  logic [SW-1:0]     idx;
  logic              pend;
  logic              dup;
  logic [AW-1:0]     rp;
  logic [DATA_W-1:0] cursor;
  logic [CNT_W-1:0]  hist_i;

  entry_t            mem [LOG_DEPTH];
  entry_t            rd_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              search_rd;
  logic              match;

  assign stored   = full ? DEPTH_S : count[SW-1:0];
  assign stored_w = CNT_W'(stored);
  assign max_sat  = (max_count > MAX_RESULTS) ? MAX_RESULTS : max_count;

  always_comb begin
    code_in = ALERT_NONE;
    case (variable_kind)
      KIND_TEMP: if (sample_value >= temp_thr) code_in = ALERT_TEMP;
      KIND_HUM:  if (sample_value >= hum_thr)  code_in = ALERT_HUM;
      KIND_ELEC: if (sample_value >= elec_thr) code_in = ALERT_ELEC;
      default:   code_in = ALERT_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_thr <= TEMP_THR_RST;
      hum_thr  <= HUM_THR_RST;
      elec_thr <= ELEC_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEMP_THR: temp_thr <= cfg_data;
        REG_HUM_THR:  hum_thr  <= cfg_data;
        REG_ELEC_THR: elec_thr <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= op;
      node_q  <= node_id;
      code_q  <= code_in;
      value_q <= sample_value;
      time_q  <= sample_time;
      n_q     <= (stored_w < max_sat) ? stored_w : max_sat;
    end
  end

  // count, full flag and write pointer (count mod depth, restarting when count wraps)
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      full   <= 1'b0;
      wr_ptr <= '0;
      wrote  <= 1'b0;
    end else begin
      if (cmd.capture) wrote <= 1'b0;
      if (cmd.write) begin
        count <= count + 32'd1;
        if ((count + 32'd1) >= 32'(LOG_DEPTH)) full <= 1'b1;
        if (count == '1 || wr_ptr == LAST_SLOT) wr_ptr <= '0;
        else wr_ptr <= wr_ptr + 1'b1;
        wrote <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) mem[wr_ptr] <= '{node: node_q, code: code_q, value: value_q, stamp: time_q};
  end

  assign search_rd = cmd.search && (idx < stored);
  assign rd_en     = search_rd || cmd.hist_rd;
  assign rd_addr   = cmd.search ? idx[AW-1:0] : rp;

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

  assign match = (rd_data.stamp == time_q) && (rd_data.node == node_q) &&
                 (rd_data.code == code_q);

  // duplicate scan: one read issued per cycle, compared the cycle after
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      idx  <= '0;
      pend <= 1'b0;
      dup  <= 1'b0;
    end else if (cmd.search) begin
      pend <= search_rd;
      if (search_rd) idx <= idx + 1'b1;
      if (pend && match) dup <= 1'b1;
    end
  end

  // history walk, newest first
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      cursor <= count - 32'd1;
      hist_i <= '0;
      if (wr_ptr != '0) rp <= wr_ptr - 1'b1;
      else if (count == '0) rp <= TOP_SLOT;
      else rp <= LAST_SLOT;
    end else if (cmd.emit_entry) begin
      cursor <= cursor - 32'd1;
      hist_i <= hist_i + 1'b1;
      if (cursor == '0) rp <= TOP_SLOT;
      else if (rp == '0) rp <= LAST_SLOT;
      else rp <= rp - 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_sample || cmd.emit_empty || cmd.emit_entry) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sample || cmd.emit_empty) begin
      result_kind  <= cmd.emit_empty ? RES_ENTRY : RES_SAMPLE;
      alert_code   <= cmd.emit_empty ? ALERT_NONE : code_q;
      newly_stored <= cmd.emit_sample && wrote;
      total_count  <= count;
      entry_valid  <= 1'b0;
      entry_node   <= '0;
      entry_value  <= '0;
      entry_time   <= '0;
      last         <= 1'b1;
    end else if (cmd.emit_entry) begin
      result_kind  <= RES_ENTRY;
      alert_code   <= rd_data.code;
      newly_stored <= 1'b0;
      total_count  <= count;
      entry_valid  <= 1'b1;
      entry_node   <= rd_data.node;
      entry_value  <= rd_data.value;
      entry_time   <= rd_data.stamp;
      last         <= status.hist_last;
    end
  end

  always_comb begin
    status.op          = op_q;
    status.alert       = (code_q != ALERT_NONE);
    status.log_empty   = (stored == '0);
    status.n_zero      = (n_q == '0);
    status.search_done = (idx == stored) && !pend;
    status.dup         = dup;
    status.out_free    = !out_valid || out_ready;
    status.hist_last   = (CNT_W'(hist_i + 1'b1) == n_q);
  end

endmodule

`default_nettype wire

// File: design/threshold_alert_ring_log_top.sv
// threshold alert ring log: a sample request is compared with its kind's threshold;
// an alert is checked against the log for a duplicate (same node, code, time)
// and, if new, written to the next slot, over the oldest once the log is full.
// a read request returns up to max_count entries, newest first, the final one flagged
// by last; an empty log or max_count of zero gives one invalid entry flagged last.
// channels: input request and output result use valid/ready; thresholds are
// written through cfg_we/cfg_index/cfg_data, by the user only while the block
// is idle; the block itself does not enforce it. requests are handled one at
// a time. a sample with no alert goes straight to its result; an alert on an
// empty log is written first; any other alert is first checked by the duplicate
// scan, which reads one log entry per cycle from the log memory (stored <= LOG_DEPTH),
// and written if new. a read gives one result per entry, or the single empty result;
// each entry is one registered memory read plus one result load.
// results sit in an output register; when out_ready is low the block holds the
// result and waits, and no request is taken until the last result is loaded.
// reset clears the count, the full flag and the result valid, and restores the
// default thresholds (40.0, 90.0, 249.0). log contents are not cleared; only
// slots already written are ever searched or returned.
// depends on tarl_pkg, tarl_ctrl and tarl_dp
`default_nettype none

module threshold_alert_ring_log_top
  import tarl_pkg::*;
#(
  parameter int LOG_DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     op,
  input  wire logic [NODE_W-1:0]        node_id,
  input  wire logic [KIND_W-1:0]        variable_kind,
  input  wire logic signed [DATA_W-1:0] sample_value,
  input  wire logic [DATA_W-1:0]        sample_time,
  input  wire logic [CNT_W-1:0]         max_count,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          result_kind,
  output logic [CODE_W-1:0]             alert_code,
  output logic                          newly_stored,
  output logic [DATA_W-1:0]             total_count,
  output logic                          entry_valid,
  output logic [NODE_W-1:0]             entry_node,
  output logic signed [DATA_W-1:0]      entry_value,
  output logic [DATA_W-1:0]             entry_time,
  output logic                          last,
  input  wire logic                     cfg_we,
  input  wire logic [1:0]               cfg_index,
  input  wire logic [DATA_W-1:0]        cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  tarl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tarl_dp #(
    .LOG_DEPTH (LOG_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .op            (op),
    .node_id       (node_id),
    .variable_kind (variable_kind),
    .sample_value  (sample_value),
    .sample_time   (sample_time),
    .max_count     (max_count),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_kind   (result_kind),
    .alert_code    (alert_code),
    .newly_stored  (newly_stored),
    .total_count   (total_count),
    .entry_valid   (entry_valid),
    .entry_node    (entry_node),
    .entry_value   (entry_value),
    .entry_time    (entry_time),
    .last          (last)
  );

endmodule

`default_nettype wire
